@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/hltp_pkg.sv @@
// Types, constants and helper functions of the hidden-line trace plotter.
`timescale 1ns / 1ps
package hltp_pkg;
	localparam logic signed [15:0] TEN_Q = 16'sd10240;
	localparam logic signed [15:0] NEG_TEN_Q = -16'sd10240;
	localparam int ZW = 16;

	localparam logic [2:0] REG_SIDE_SELECT  = 3'd0;
	localparam logic [2:0] REG_TRACE_LENGTH = 3'd1;
	localparam logic [2:0] REG_MASK_STEP    = 3'd2;
	localparam logic [2:0] REG_X_STEP       = 3'd3;
	localparam logic [2:0] REG_X_ORIGIN     = 3'd4;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_SHIFT, ST_SHIFT_END, ST_EMIT_S,
		ST_RD_P, ST_RD_C, ST_EVAL, ST_SETUP, ST_DIV, ST_MUL,
		ST_EMIT_A, ST_EMIT_B, ST_EMIT_C
	} state_t;

	typedef enum logic [2:0] {
		SEG_VIS, SEG_HID, SEG_IN, SEG_OUT, SEG_NONE
	} seg_t;

	typedef enum logic [1:0] {
		SRC_START, SRC_CROSS, SRC_POINT, SRC_END
	} src_t;

	typedef struct packed {
		logic in_take;
		logic clr_start;
		logic clr_step;
		logic shift_start;
		logic shift_step;
		logic shift_end;
		logic rd_prev;
		logic rd_cur;
		logic eval;
		logic setup;
		logic div_step;
		logic mul;
		logic emit;
		src_t emit_src;
		logic emit_draw;
		logic emit_last;
	} hltp_cmd_t;

	typedef struct packed {
		logic in_clear;
		logic idx_zero;
		logic sweep_done;
		logic shift_done;
		seg_t seg;
		logic div_skip;
		logic div_done;
		logic out_free;
		logic last_seg;
	} hltp_stat_t;

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		if (v > 20'sd32767) begin
			return 16'sd32767;
		end else if (v < -20'sd32768) begin
			return -16'sd32768;
		end
		return v[15:0];
	endfunction
endpackage

@@ src/hidden_line_trace_plotter_top.sv @@
// Top level of the hidden-line trace plotter.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//   Input channel (in_valid/in_ready, cmd, sample) takes one sample or a
//   clear command per transaction. Output channel (out_valid/out_ready)
//   carries pen commands; last_result marks the final one for each sample.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
//   always ready; write it only while the block is idle.
// Operation:
//   Trace start: runs the mask shift sweep through the mask memory,
//   one entry per cycle.
//   Later samples: a segment that crosses the horizon also runs the
//   16-bit restoring divider.
//   Clear command: runs a sweep of the mask memory.
// Reset:
//   After reset the block sweeps both masks to +/-10 with in_ready low.
// Stall:
//   A result waits in the output register and the block holds until it is
//   taken; the next input is accepted once the last result is in the register.
module hidden_line_trace_plotter_top import hltp_pkg::*; #(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic signed [15:0] sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               pen_draw,
	output logic [23:0]        x_pos,
	output logic signed [15:0] y_val,
	output logic               last_result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);
	hltp_cmd_t  dp_cmd;
	hltp_stat_t dp_stat;

	assign cfg_ready = 1'b1;

	hltp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (dp_stat),
		.cmd_o    (dp_cmd)
	);

	hltp_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_i       (dp_cmd),
		.stat        (dp_stat),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pen_draw    (pen_draw),
		.x_pos       (x_pos),
		.y_val       (y_val),
		.last_result (last_result)
	);

	`ASSERT_NEXT(a_take_blocks, clk, arst_n, in_valid && in_ready, !in_ready, "input taken while busy")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(x_pos) && $stable(y_val), "result dropped while stalled")
	`ASSERT_SAME(a_pending_busy, clk, arst_n, out_valid && !last_result, !in_ready, "ready with results pending")
endmodule

@@ src/hltp_ctrl.sv @@
// Controller state machine of the hidden-line trace plotter.
`timescale 1ns / 1ps
module hltp_ctrl import hltp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  hltp_stat_t stat,
	output hltp_cmd_t  cmd_o
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd_o    = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd_o.clr_step = 1'b1;
				if (stat.sweep_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd_o.in_take = 1'b1;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (stat.in_clear) begin
					cmd_o.clr_start = 1'b1;
					state_d = ST_CLEAR;
				end else if (stat.idx_zero) begin
					cmd_o.shift_start = 1'b1;
					state_d = ST_SHIFT;
				end else begin
					state_d = ST_RD_P;
				end
			end
			ST_SHIFT: begin
				if (stat.shift_done) begin
					state_d = ST_SHIFT_END;
				end else begin
					cmd_o.shift_step = 1'b1;
				end
			end
			ST_SHIFT_END: begin
				cmd_o.shift_end = 1'b1;
				state_d = ST_EMIT_S;
			end
			ST_EMIT_S: begin
				if (stat.out_free) begin
					cmd_o.emit = 1'b1;
					cmd_o.emit_src = SRC_START;
					cmd_o.emit_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_RD_P: begin
				cmd_o.rd_prev = 1'b1;
				state_d = ST_RD_C;
			end
			ST_RD_C: begin
				cmd_o.rd_cur = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd_o.eval = 1'b1;
				state_d = ST_SETUP;
			end
			ST_SETUP: begin
				if (stat.seg == SEG_IN || stat.seg == SEG_OUT) begin
					cmd_o.setup = 1'b1;
					state_d = ST_DIV;
				end else begin
					state_d = ST_EMIT_B;
				end
			end
			ST_DIV: begin
				if (stat.div_skip) begin
					state_d = ST_MUL;
				end else begin
					cmd_o.div_step = 1'b1;
					if (stat.div_done) begin
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				cmd_o.mul = 1'b1;
				state_d = ST_EMIT_A;
			end
			ST_EMIT_A: begin
				if (stat.out_free) begin
					cmd_o.emit = 1'b1;
					cmd_o.emit_src = SRC_CROSS;
					cmd_o.emit_draw = (stat.seg == SEG_IN);
					state_d = ST_EMIT_B;
				end
			end
			ST_EMIT_B: begin
				if (stat.out_free) begin
					cmd_o.emit = 1'b1;
					cmd_o.emit_src = SRC_POINT;
					cmd_o.emit_draw = (stat.seg == SEG_VIS || stat.seg == SEG_OUT);
					cmd_o.emit_last = !stat.last_seg;
					state_d = stat.last_seg ? ST_EMIT_C : ST_IDLE;
				end
			end
			ST_EMIT_C: begin
				if (stat.out_free) begin
					cmd_o.emit = 1'b1;
					cmd_o.emit_src = SRC_END;
					cmd_o.emit_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end
endmodule

@@ src/hltp_dp.sv @@
// Datapath of the hidden-line trace plotter: masks, divider, multipliers, output register.
`timescale 1ns / 1ps
module hltp_dp import hltp_pkg::*; #(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hltp_cmd_t           cmd_i,
	output hltp_stat_t          stat,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	input  logic                cmd,
	input  logic signed [15:0]  sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                pen_draw,
	output logic [23:0]         x_pos,
	output logic signed [15:0]  y_val,
	output logic                last_result
);
	localparam int DEPTH = MAX_SAMPLES + 1;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam int IW = $clog2(MAX_SAMPLES);

	logic               side_q;
	logic [12:0]        tlen_q;
	logic signed [15:0] mstep_q;
	logic [15:0]        xstep_q;
	logic [23:0]        xorig_q;

	logic signed [15:0] upper_mem [DEPTH];
	logic signed [15:0] lower_mem [DEPTH];
	logic signed [15:0] ru_q, rl_q, rd;
	logic               we_u, we_l;
	logic [AW-1:0]      waddr, raddr;
	logic signed [15:0] wdata_u, wdata_l;

	logic               cmd_q;
	logic signed [15:0] sample_q;
	logic [CW-1:0]      cnt_q;
	logic               pend_q;
	logic [AW-1:0]      paddr_q;
	logic [IW-1:0]      idx_q;
	logic [23:0]        xpos_q, x1_q, x2_q;
	logic signed [15:0] prev_q, f1_q, held_q, mp_q, mc_q;
	seg_t               seg_q;
	logic               last_q;
	logic [AW-1:0]      len_eff, idx_a;

	logic [18:0]        rem_q, den_q;
	logic [ZW-1:0]      z_q;
	logic [3:0]         dcnt_q;
	logic               skip_q;
	logic [23:0]        cross_x_q;
	logic signed [15:0] cross_y_q;

	logic               out_valid_q;

	always_comb begin
		if (tlen_q < 13'd2) begin
			len_eff = AW'(2);
		end else if (32'(tlen_q) > MAX_SAMPLES) begin
			len_eff = AW'(MAX_SAMPLES);
		end else begin
			len_eff = AW'(tlen_q);
		end
	end

	assign idx_a = AW'(idx_q);
	assign rd = side_q ? rl_q : ru_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q  <= 1'b0;
			tlen_q  <= 13'd1024;
			mstep_q <= '0;
			xstep_q <= 16'd4096;
			xorig_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIDE_SELECT:  side_q  <= cfg_data[0];
				REG_TRACE_LENGTH: tlen_q  <= cfg_data[12:0];
				REG_MASK_STEP:    mstep_q <= cfg_data[15:0];
				REG_X_STEP:       xstep_q <= cfg_data[15:0];
				REG_X_ORIGIN:     xorig_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Segment classification
	logic signed [17:0] g1, g2, mp_e, mc_e, held_e;
	logic               vis, hid, c_in, c_out;
	logic [24:0]        x2_sum;
	logic [23:0]        x2_n;

	always_comb begin
		g1 = -(18'(prev_q));
		g2 = -(18'(sample_q));
		mp_e = 18'(mp_q);
		mc_e = 18'(rd);
		held_e = 18'(held_q);
		if (!side_q) begin
			vis   = (g1 <= mp_e) && (g2 <= mc_e);
			hid   = (g1 > mp_e) && (g2 > mc_e);
			c_in  = (g1 < held_e) && (g2 > mc_e);
			c_out = (g1 > mp_e) && (g2 < mc_e);
		end else begin
			vis   = (g1 >= mp_e) && (g2 >= mc_e);
			hid   = (g1 < mp_e) && (g2 < mc_e);
			c_in  = (g1 > held_e) && (g2 < mc_e);
			c_out = (g1 < mp_e) && (g2 > mc_e);
		end
		x2_sum = 25'(xpos_q) + 25'(xstep_q);
		x2_n = x2_sum[24] ? 24'hFFFFFF : x2_sum[23:0];
	end

	// Memory ports
	always_comb begin
		we_u = 1'b0;
		we_l = 1'b0;
		waddr = '0;
		wdata_u = TEN_Q;
		wdata_l = NEG_TEN_Q;
		raddr = '0;
		if (cmd_i.clr_step) begin
			we_u = 1'b1;
			we_l = 1'b1;
			waddr = cnt_q[AW-1:0];
		end else if (cmd_i.shift_step && pend_q) begin
			we_u = !side_q;
			we_l = side_q;
			waddr = paddr_q;
			wdata_u = sat16(20'(rd) + 20'(mstep_q));
			wdata_l = wdata_u;
		end else if (cmd_i.shift_end) begin
			we_u = !side_q;
			we_l = side_q;
			waddr = len_eff;
		end else if (cmd_i.eval && (vis || (!hid && !c_in && c_out))) begin
			we_u = !side_q;
			we_l = side_q;
			waddr = idx_a;
			wdata_u = sat16(20'(g2));
			wdata_l = wdata_u;
		end
		if (cmd_i.shift_step) begin
			raddr = cnt_q[AW-1:0];
		end else if (cmd_i.rd_prev) begin
			raddr = idx_a - AW'(1);
		end else if (cmd_i.rd_cur) begin
			raddr = idx_a;
		end
	end

	always_ff @(posedge clk) begin
		if (we_u) begin
			upper_mem[waddr] <= wdata_u;
		end
		if (we_l) begin
			lower_mem[waddr] <= wdata_l;
		end
		ru_q <= upper_mem[raddr];
		rl_q <= lower_mem[raddr];
	end

	// Sequencing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
			idx_q  <= '0;
			xpos_q <= '0;
			prev_q <= '0;
			held_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd_i.clr_start) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else if (cmd_i.clr_step) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd_i.shift_start) begin
				cnt_q  <= CW'(1);
				pend_q <= 1'b0;
			end else if (cmd_i.shift_step) begin
				if (cnt_q <= CW'(len_eff)) begin
					cnt_q  <= cnt_q + CW'(1);
					pend_q <= 1'b1;
				end else begin
					pend_q <= 1'b0;
				end
			end
			if (cmd_i.shift_end) begin
				xpos_q <= xorig_q;
				prev_q <= sample_q;
				idx_q  <= IW'(1);
			end
			if (cmd_i.eval) begin
				xpos_q <= x2_n;
				prev_q <= sample_q;
				if (idx_a >= len_eff - AW'(1)) begin
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
				if (vis || (!hid && !c_in && c_out)) begin
					held_q <= rd;
				end
			end
			if (cmd_i.setup) begin
				dcnt_q <= '0;
			end else if (cmd_i.div_step) begin
				dcnt_q <= dcnt_q + 4'd1;
			end
		end
	end

	// Crossing setup, divider and interpolation
	logic signed [17:0] m1;
	logic signed [19:0] num, den, nn, dd;
	logic [19:0]        r2;
	logic [15:0]        dx;
	logic [31:0]        px;
	logic signed [16:0] df;
	logic signed [33:0] py;
	logic signed [33:0] py_sh;
	logic signed [16:0] cy;

	always_comb begin
		m1 = (seg_q == SEG_IN) ? held_e : 18'(mp_q);
		num = 20'(-(18'(f1_q))) - 20'(m1);
		den = num + 20'(mc_q) + 20'(sample_q);
		nn = den[19] ? -num : num;
		dd = den[19] ? -den : den;
		r2 = {rem_q, 1'b0};
		dx = 16'(x2_q - x1_q);
		px = 32'(z_q) * 32'(dx);
		df = 17'(sample_q) - 17'(f1_q);
		py = $signed({18'd0, z_q}) * 34'(df);
		py_sh = py >>> 16;
		cy = 17'(f1_q) + py_sh[16:0];
	end

	always_ff @(posedge clk) begin
		if (cmd_i.in_take) begin
			cmd_q <= cmd;
			sample_q <= sample;
		end
		if (cmd_i.shift_step) begin
			paddr_q <= cnt_q[AW-1:0] - AW'(1);
		end
		if (cmd_i.rd_cur) begin
			mp_q <= rd;
		end
		if (cmd_i.eval) begin
			mc_q <= rd;
			f1_q <= prev_q;
			x1_q <= xpos_q;
			x2_q <= x2_n;
			last_q <= (idx_a >= len_eff - AW'(1));
			priority if (vis) begin
				seg_q <= SEG_VIS;
			end else if (hid) begin
				seg_q <= SEG_HID;
			end else if (c_in) begin
				seg_q <= SEG_IN;
			end else if (c_out) begin
				seg_q <= SEG_OUT;
			end else begin
				seg_q <= SEG_NONE;
			end
		end
		if (cmd_i.setup) begin
			rem_q <= nn[18:0];
			den_q <= dd[18:0];
			skip_q <= (dd == 20'sd0) || (nn <= 20'sd0) || (nn >= dd);
			z_q <= ((dd != 20'sd0) && (nn > 20'sd0) && (nn >= dd)) ? {ZW{1'b1}} : '0;
		end else if (cmd_i.div_step) begin
			if (r2 >= {1'b0, den_q}) begin
				rem_q <= 19'(r2 - {1'b0, den_q});
				z_q <= {z_q[ZW-2:0], 1'b1};
			end else begin
				rem_q <= r2[18:0];
				z_q <= {z_q[ZW-2:0], 1'b0};
			end
		end
		if (cmd_i.mul) begin
			cross_x_q <= x1_q + 24'(px[31:16]);
			cross_y_q <= cy[15:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_i.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.emit) begin
			pen_draw <= cmd_i.emit_draw;
			last_result <= cmd_i.emit_last;
			unique case (cmd_i.emit_src)
				SRC_START: begin
					x_pos <= xorig_q;
					y_val <= sample_q;
				end
				SRC_CROSS: begin
					x_pos <= cross_x_q;
					y_val <= cross_y_q;
				end
				SRC_POINT: begin
					x_pos <= x2_q;
					y_val <= sample_q;
				end
				SRC_END: begin
					x_pos <= x2_q;
					y_val <= '0;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat.in_clear   = cmd_q;
		stat.idx_zero   = (idx_q == '0);
		stat.sweep_done = (cnt_q == CW'(MAX_SAMPLES));
		stat.shift_done = (cnt_q > CW'(len_eff)) && !pend_q;
		stat.seg        = seg_q;
		stat.div_skip   = skip_q;
		stat.div_done   = (dcnt_q == 4'd15);
		stat.out_free   = !out_valid_q || out_ready;
		stat.last_seg   = last_q;
	end
endmodule
